[hw/rtl/cda_pkg.sv]
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar helpers for the date-time arithmetic
// block: transaction payloads, datapath commands and status, month lengths.
// ----------------------------------------------------------------------------
package cda_pkg;

    // field widths
    localparam int AMOUNT_BITS = 16;
    localparam int YEAR_BITS   = 16;

    // accumulator must hold an amount plus up to 30 extra days
    localparam int ACC_BITS = ((AMOUNT_BITS > 5) ? AMOUNT_BITS : 5) + 1;
    // divider dividend and divisor widths
    localparam int DIV_BITS = (ACC_BITS > YEAR_BITS) ? ACC_BITS : YEAR_BITS;
    localparam int DVS_BITS = (AMOUNT_BITS > 9) ? AMOUNT_BITS : 9;
    // width for comparing the accumulator against a year span
    localparam int CMP_BITS = (ACC_BITS > 9) ? ACC_BITS : 9;

    // gregorian cycle and calendar constants
    localparam int YEAR_CYCLE = 400;
    localparam logic [8:0] RES_LAST = 9'(YEAR_CYCLE - 1);
    localparam logic [8:0] RES_WRAP =
        9'(((64'd1 << YEAR_BITS) - 64'd1) % 64'(YEAR_CYCLE));
    localparam logic [8:0] DAYS_YEAR = 9'd365;
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [3:0] MONTH_MAX = 4'd12;

    // fixed moduli of the carry chain
    localparam logic [8:0] MOD_SEC   = 9'd60;
    localparam logic [8:0] MOD_HOUR  = 9'd24;
    localparam logic [8:0] MOD_MONTH = 9'd12;
    localparam logic [8:0] MOD_CYCLE = 9'(YEAR_CYCLE);

    // reciprocals for exact division of a DIV_BITS value by a modulus below 512
    localparam int RCP_SHIFT = DIV_BITS + 9;
    localparam int RCP_BITS  = RCP_SHIFT - 3;
    localparam logic [RCP_BITS-1:0] RCP_SEC   =
        RCP_BITS'(((64'd1 << RCP_SHIFT) + 64'd59) / 64'd60);
    localparam logic [RCP_BITS-1:0] RCP_HOUR  =
        RCP_BITS'(((64'd1 << RCP_SHIFT) + 64'd23) / 64'd24);
    localparam logic [RCP_BITS-1:0] RCP_MONTH =
        RCP_BITS'(((64'd1 << RCP_SHIFT) + 64'd11) / 64'd12);
    localparam logic [RCP_BITS-1:0] RCP_CYCLE =
        RCP_BITS'(((64'd1 << RCP_SHIFT) + 64'(YEAR_CYCLE - 1)) / 64'(YEAR_CYCLE));

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_SUB   = 2'd2;
    localparam logic [1:0] CMD_ALIGN = 2'd3;

    // unit codes
    localparam logic [2:0] UNIT_SECOND = 3'd0;
    localparam logic [2:0] UNIT_MINUTE = 3'd1;
    localparam logic [2:0] UNIT_HOUR   = 3'd2;
    localparam logic [2:0] UNIT_DAY    = 3'd3;
    localparam logic [2:0] UNIT_MONTH  = 3'd4;
    localparam logic [2:0] UNIT_YEAR   = 3'd5;

    typedef struct packed {
        logic [1:0]             command;
        logic [2:0]             unit;
        logic [AMOUNT_BITS-1:0] amount;
        logic [YEAR_BITS-1:0]   load_year;
        logic [3:0]             load_month;
        logic [4:0]             load_day;
        logic [4:0]             load_hour;
        logic [5:0]             load_minute;
        logic [5:0]             load_second;
    } in_item_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0] out_year;
        logic [3:0]           out_month;
        logic [4:0]           out_day;
        logic [4:0]           out_hour;
        logic [5:0]           out_minute;
        logic [5:0]           out_second;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SUB_FAST,
        OP_DIV_ADD,
        OP_DIV_SUB,
        OP_DIV_ALIGN,
        OP_DIV_RES,
        OP_WR_ADD,
        OP_WR_SUB,
        OP_WR_ALIGN,
        OP_WR_RES,
        OP_YEAR_ADJ,
        OP_DAYS_INIT,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_DAYS_FIN,
        OP_CLAMP,
        OP_ALIGN_CLEAR,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] fld;
        logic       sub;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic acc_zero;
        logic acc_le_fld;
        logic amt_gt1;
        logic span_fit;
        logic month_fit;
    } dp_stat_t;

    // days in a month, month one-based
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // leap test from the year modulo 400
    function automatic logic res_leap(input logic [8:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

endpackage

[hw/rtl/cda_divider.sv]
// ----------------------------------------------------------------------------
// cda_divider
// Restoring divider, one quotient bit per cycle; quotient and remainder stay
// registered until the next start.
// ----------------------------------------------------------------------------
module cda_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cda_pkg::DIV_BITS-1:0]   dividend,
    input  logic [cda_pkg::DVS_BITS-1:0]   divisor,
    output logic                           done,
    output logic [cda_pkg::DIV_BITS-1:0]   quo,
    output logic [cda_pkg::DVS_BITS-1:0]   rem
);
    import cda_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DVS_BITS:0]   shifted;
    logic                ge;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_BITS-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_BITS'(DIV_BITS);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[DIV_BITS-2:0], ge};
            rem_next = ge ? DVS_BITS'(shifted - {1'b0, dvs_reg}) : shifted[DVS_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[hw/rtl/cda_datapath.sv]
// ----------------------------------------------------------------------------
// cda_datapath
// Date-time registers, amount accumulator, year residue tracker, a reciprocal
// divider for the fixed moduli and a bit-serial divider for align steps;
// executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module cda_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cda_pkg::dp_cmd_t     cmd,
    output cda_pkg::dp_stat_t    stat,
    input  cda_pkg::in_item_t    item,
    output cda_pkg::out_item_t   result
);
    import cda_pkg::*;

    typedef enum logic [1:0] {
        RQ_IDLE,
        RQ_QUO,
        RQ_REM
    } rq_phase_t;

    logic [YEAR_BITS-1:0]   year_reg, year_next;
    logic [3:0]             month_reg, month_next;
    logic [4:0]             day_reg, day_next;
    logic [4:0]             hour_reg, hour_next;
    logic [5:0]             minute_reg, minute_next;
    logic [5:0]             second_reg, second_next;
    logic [8:0]             res_reg, res_next;
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [AMOUNT_BITS-1:0] amt_reg, amt_next;
    out_item_t              result_reg, result_next;

    logic [8:0]          res_inc, res_dec;
    logic                leap_cur, leap_nxt, leap_prv, span_leap;
    logic [4:0]          mlen;
    logic [8:0]          span;
    logic [DIV_BITS-1:0] mod_val, raw_val;
    logic [8:0]          modulus;
    logic [RCP_BITS-1:0] recip;
    logic                div_start, div_done;
    logic [DIV_BITS-1:0] quo;
    logic [DVS_BITS-1:0] rem;

    // reciprocal divider
    logic                         rq_start;
    logic [DIV_BITS-1:0]          rq_dividend;
    logic [8:0]                   rq_divisor;
    logic [RCP_BITS-1:0]          rq_recip;
    rq_phase_t                    rq_phase_reg, rq_phase_next;
    logic                         rq_done_reg, rq_done_next;
    logic [DIV_BITS-1:0]          rq_dvd_reg, rq_dvd_next;
    logic [DIV_BITS-1:0]          rq_quo_reg, rq_quo_next;
    logic [8:0]                   rq_dvs_reg, rq_dvs_next;
    logic [8:0]                   rq_rem_reg, rq_rem_next;
    logic [RCP_BITS-1:0]          rq_rcp_reg, rq_rcp_next;
    logic [DIV_BITS+RCP_BITS-1:0] rq_prod;
    logic [DIV_BITS-1:0]          rq_back;

    // neighbor year residues, with the year wrap
    always_comb
    begin
        if (year_reg == {YEAR_BITS{1'b1}})
            res_inc = '0;
        else
            res_inc = (res_reg == RES_LAST) ? 9'd0 : res_reg + 9'd1;
        if (year_reg == '0)
            res_dec = RES_WRAP;
        else
            res_dec = (res_reg == 9'd0) ? RES_LAST : res_reg - 9'd1;
    end

    // month length and year span
    always_comb
    begin
        leap_cur = res_leap(res_reg);
        leap_nxt = res_leap(res_inc);
        leap_prv = res_leap(res_dec);
        mlen     = month_len(month_reg, leap_cur);
        if (cmd.sub)
            span_leap = (month_reg >= 4'd2) ? leap_cur : leap_prv;
        else
            span_leap = (month_reg <= 4'd2) ? leap_cur : leap_nxt;
        span = DAYS_YEAR + {8'd0, span_leap};
    end

    // field selection for carries and alignment
    always_comb
    begin
        case (cmd.fld)
            UNIT_SECOND: mod_val = DIV_BITS'(second_reg);
            UNIT_MINUTE: mod_val = DIV_BITS'(minute_reg);
            UNIT_HOUR:   mod_val = DIV_BITS'(hour_reg);
            UNIT_MONTH:  mod_val = DIV_BITS'(month_reg - 4'd1);
            default:     mod_val = '0;
        endcase
        case (cmd.fld)
            UNIT_SECOND: raw_val = DIV_BITS'(second_reg);
            UNIT_MINUTE: raw_val = DIV_BITS'(minute_reg);
            UNIT_HOUR:   raw_val = DIV_BITS'(hour_reg);
            UNIT_DAY:    raw_val = DIV_BITS'(day_reg);
            UNIT_MONTH:  raw_val = DIV_BITS'(month_reg);
            UNIT_YEAR:   raw_val = DIV_BITS'(year_reg);
            default:     raw_val = '0;
        endcase
        case (cmd.fld)
            UNIT_SECOND:
            begin
                modulus = MOD_SEC;
                recip   = RCP_SEC;
            end
            UNIT_MINUTE:
            begin
                modulus = MOD_SEC;
                recip   = RCP_SEC;
            end
            UNIT_HOUR:
            begin
                modulus = MOD_HOUR;
                recip   = RCP_HOUR;
            end
            default:
            begin
                modulus = MOD_MONTH;
                recip   = RCP_MONTH;
            end
        endcase
    end

    // divider operands
    always_comb
    begin
        div_start   = (cmd.op == OP_DIV_ALIGN);
        rq_start    = 1'b0;
        rq_dividend = '0;
        rq_divisor  = modulus;
        rq_recip    = recip;
        case (cmd.op)
            OP_DIV_ADD:
            begin
                rq_start    = 1'b1;
                rq_dividend = DIV_BITS'(acc_reg) + mod_val;
            end
            OP_DIV_SUB:
            begin
                rq_start    = 1'b1;
                rq_dividend = DIV_BITS'(acc_reg) - mod_val - DIV_BITS'(1);
            end
            OP_DIV_RES:
            begin
                rq_start    = 1'b1;
                rq_dividend = DIV_BITS'(year_reg);
                rq_divisor  = MOD_CYCLE;
                rq_recip    = RCP_CYCLE;
            end
            default:
            begin
                rq_start = 1'b0;
            end
        endcase
    end

    // align steps: bit-serial division by the amount
    cda_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (raw_val),
        .divisor  (DVS_BITS'(amt_reg)),
        .done     (div_done),
        .quo      (quo),
        .rem      (rem)
    );

    // fixed moduli: quotient by reciprocal multiply, then remainder
    always_comb
    begin
        rq_prod       = (DIV_BITS + RCP_BITS)'(rq_dvd_reg) * (DIV_BITS + RCP_BITS)'(rq_rcp_reg);
        rq_back       = rq_quo_reg * DIV_BITS'(rq_dvs_reg);
        rq_phase_next = rq_phase_reg;
        rq_dvd_next   = rq_dvd_reg;
        rq_dvs_next   = rq_dvs_reg;
        rq_rcp_next   = rq_rcp_reg;
        rq_quo_next   = rq_quo_reg;
        rq_rem_next   = rq_rem_reg;
        rq_done_next  = 1'b0;
        if (rq_start)
        begin
            rq_dvd_next   = rq_dividend;
            rq_dvs_next   = rq_divisor;
            rq_rcp_next   = rq_recip;
            rq_phase_next = RQ_QUO;
        end
        else
        begin
            case (rq_phase_reg)
                RQ_QUO:
                begin
                    rq_quo_next   = DIV_BITS'(rq_prod >> RCP_SHIFT);
                    rq_phase_next = RQ_REM;
                end
                RQ_REM:
                begin
                    rq_rem_next   = 9'(rq_dvd_reg - rq_back);
                    rq_done_next  = 1'b1;
                    rq_phase_next = RQ_IDLE;
                end
                default:
                begin
                    rq_phase_next = RQ_IDLE;
                end
            endcase
        end
    end

    // register updates per command
    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        res_next    = res_reg;
        acc_next    = acc_reg;
        amt_next    = amt_reg;
        result_next = result_reg;
        case (cmd.op)
            OP_CAPTURE:
            begin
                amt_next = item.amount;
                acc_next = ACC_BITS'(item.amount);
                if (item.command == CMD_LOAD)
                begin
                    year_next = item.load_year;
                    if (item.load_month == 4'd0)
                        month_next = 4'd1;
                    else if (item.load_month > MONTH_MAX)
                        month_next = MONTH_MAX;
                    else
                        month_next = item.load_month;
                    day_next    = item.load_day;
                    hour_next   = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
                    minute_next = (item.load_minute > SEC_MAX) ? SEC_MAX : item.load_minute;
                    second_next = (item.load_second > SEC_MAX) ? SEC_MAX : item.load_second;
                end
            end
            OP_SUB_FAST:
            begin
                case (cmd.fld)
                    UNIT_SECOND: second_next = second_reg - 6'(acc_reg);
                    UNIT_MINUTE: minute_next = minute_reg - 6'(acc_reg);
                    UNIT_HOUR:   hour_next   = hour_reg - 5'(acc_reg);
                    UNIT_MONTH:  month_next  = month_reg - 4'(acc_reg);
                    default:     acc_next    = '0;
                endcase
                acc_next = '0;
            end
            OP_WR_ADD:
            begin
                case (cmd.fld)
                    UNIT_SECOND: second_next = 6'(rq_rem_reg);
                    UNIT_MINUTE: minute_next = 6'(rq_rem_reg);
                    UNIT_HOUR:   hour_next   = 5'(rq_rem_reg);
                    UNIT_MONTH:  month_next  = 4'(rq_rem_reg) + 4'd1;
                    default:     month_next  = month_reg;
                endcase
                acc_next = ACC_BITS'(rq_quo_reg);
            end
            OP_WR_SUB:
            begin
                case (cmd.fld)
                    UNIT_SECOND: second_next = SEC_MAX - 6'(rq_rem_reg);
                    UNIT_MINUTE: minute_next = SEC_MAX - 6'(rq_rem_reg);
                    UNIT_HOUR:   hour_next   = HOUR_MAX - 5'(rq_rem_reg);
                    UNIT_MONTH:  month_next  = MONTH_MAX - 4'(rq_rem_reg);
                    default:     month_next  = month_reg;
                endcase
                acc_next = ACC_BITS'(rq_quo_reg) + ACC_BITS'(1);
            end
            OP_WR_ALIGN:
            begin
                case (cmd.fld)
                    UNIT_SECOND: second_next = second_reg - 6'(rem);
                    UNIT_MINUTE: minute_next = minute_reg - 6'(rem);
                    UNIT_HOUR:   hour_next   = hour_reg - 5'(rem);
                    UNIT_DAY:
                    begin
                        day_next = day_reg - 5'(rem);
                        if (day_reg == 5'(rem))
                            day_next = 5'd1;
                    end
                    UNIT_MONTH:
                    begin
                        month_next = month_reg - 4'(rem);
                        if (month_reg == 4'(rem))
                            month_next = 4'd1;
                    end
                    UNIT_YEAR:   year_next = year_reg - YEAR_BITS'(rem);
                    default:     year_next = year_reg;
                endcase
            end
            OP_WR_RES:
            begin
                res_next = rq_rem_reg;
            end
            OP_YEAR_ADJ:
            begin
                if (cmd.sub)
                    year_next = year_reg - YEAR_BITS'(acc_reg);
                else
                    year_next = year_reg + YEAR_BITS'(acc_reg);
            end
            OP_DAYS_INIT:
            begin
                if (cmd.sub)
                    acc_next = acc_reg + ACC_BITS'(mlen) - ACC_BITS'(day_reg);
                else
                begin
                    acc_next = acc_reg + ACC_BITS'(day_reg) - ACC_BITS'(1);
                    day_next = 5'd1;
                end
            end
            OP_YEAR_STEP:
            begin
                acc_next = acc_reg - ACC_BITS'(span);
                if (cmd.sub)
                begin
                    year_next = year_reg - 1'b1;
                    res_next  = res_dec;
                end
                else
                begin
                    year_next = year_reg + 1'b1;
                    res_next  = res_inc;
                end
            end
            OP_MONTH_STEP:
            begin
                acc_next = acc_reg - ACC_BITS'(mlen);
                if (cmd.sub)
                begin
                    if (month_reg <= 4'd1)
                    begin
                        month_next = MONTH_MAX;
                        year_next  = year_reg - 1'b1;
                        res_next   = res_dec;
                    end
                    else
                        month_next = month_reg - 4'd1;
                end
                else
                begin
                    if (month_reg >= MONTH_MAX)
                    begin
                        month_next = 4'd1;
                        year_next  = year_reg + 1'b1;
                        res_next   = res_inc;
                    end
                    else
                        month_next = month_reg + 4'd1;
                end
            end
            OP_DAYS_FIN:
            begin
                if (cmd.sub)
                    day_next = mlen - 5'(acc_reg);
                else
                    day_next = 5'(acc_reg) + 5'd1;
            end
            OP_CLAMP:
            begin
                if (day_reg > mlen)
                    day_next = mlen;
                else if (day_reg == 5'd0)
                    day_next = 5'd1;
            end
            OP_ALIGN_CLEAR:
            begin
                if (cmd.fld >= UNIT_MINUTE)
                    second_next = 6'd0;
                if (cmd.fld >= UNIT_HOUR)
                    minute_next = 6'd0;
                if (cmd.fld >= UNIT_DAY)
                    hour_next = 5'd0;
                if (cmd.fld >= UNIT_MONTH)
                    day_next = 5'd1;
                if (cmd.fld >= UNIT_YEAR)
                    month_next = 4'd1;
            end
            OP_EMIT:
            begin
                result_next.out_year   = year_reg;
                result_next.out_month  = month_reg;
                result_next.out_day    = day_reg;
                result_next.out_hour   = hour_reg;
                result_next.out_minute = minute_reg;
                result_next.out_second = second_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // date-time state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg     <= '0;
            month_reg    <= 4'd1;
            day_reg      <= 5'd1;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
            res_reg      <= '0;
            rq_phase_reg <= RQ_IDLE;
            rq_done_reg  <= 1'b0;
        end
        else
        begin
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            res_reg      <= res_next;
            rq_phase_reg <= rq_phase_next;
            rq_done_reg  <= rq_done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        amt_reg    <= amt_next;
        result_reg <= result_next;
        rq_dvd_reg <= rq_dvd_next;
        rq_dvs_reg <= rq_dvs_next;
        rq_rcp_reg <= rq_rcp_next;
        rq_quo_reg <= rq_quo_next;
        rq_rem_reg <= rq_rem_next;
    end

    // status to the controller
    always_comb
    begin
        stat.div_done   = div_done | rq_done_reg;
        stat.acc_zero   = (acc_reg == '0);
        stat.acc_le_fld = (DIV_BITS'(acc_reg) <= mod_val);
        stat.amt_gt1    = (amt_reg > AMOUNT_BITS'(1));
        stat.span_fit   = (CMP_BITS'(acc_reg) < CMP_BITS'(span));
        stat.month_fit  = (acc_reg < ACC_BITS'(mlen));
    end

    assign result = result_reg;

endmodule

[hw/rtl/cda_ctrl.sv]
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer: walks the unit cascade, drives divider runs and the day, month
// and year loops, and owns both transaction handshakes.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          item_command,
    input  logic [2:0]          item_unit,
    output logic                result_valid,
    input  logic                result_ready,
    output cda_pkg::dp_cmd_t    cmd,
    input  cda_pkg::dp_stat_t   stat
);
    import cda_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_STEP,
        S_DIV_WAIT,
        S_DAYS_INIT,
        S_YEAR_LOOP,
        S_MONTH_LOOP,
        S_DAYS_FIN,
        S_RES_START,
        S_CLAMP,
        S_ALIGN,
        S_ALIGN_DIV,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        KIND_STEP,
        KIND_RES,
        KIND_ALIGN
    } kind_t;

    state_t     state_reg, state_next;
    kind_t      kind_reg, kind_next;
    logic [1:0] command_reg, command_next;
    logic [2:0] fld_reg, fld_next;
    logic       ready_reg, ready_next;
    logic       valid_reg, valid_next;
    logic       sub;

    assign sub = (command_reg == CMD_SUB);

    // next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        command_next = command_reg;
        fld_next     = fld_reg;
        ready_next   = ready_reg;
        valid_next   = valid_reg;
        cmd.op       = OP_NONE;
        cmd.fld      = fld_reg;
        cmd.sub      = sub;

        if (valid_reg && result_ready)
            valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && ready_reg)
                begin
                    cmd.op       = OP_CAPTURE;
                    command_next = item_command;
                    fld_next     = item_unit;
                    ready_next   = 1'b0;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (command_reg == CMD_LOAD)
                    state_next = S_RES_START;
                else if (fld_reg > UNIT_YEAR)
                    state_next = S_DONE;
                else if (command_reg == CMD_ALIGN)
                    state_next = S_ALIGN;
                else
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (stat.acc_zero && fld_reg != UNIT_YEAR)
                    state_next = S_DONE;
                else if (fld_reg == UNIT_DAY)
                    state_next = S_DAYS_INIT;
                else if (fld_reg == UNIT_YEAR)
                begin
                    cmd.op     = OP_YEAR_ADJ;
                    state_next = S_RES_START;
                end
                else if (sub && stat.acc_le_fld)
                begin
                    cmd.op   = OP_SUB_FAST;
                    fld_next = fld_reg + 3'd1;
                end
                else
                begin
                    cmd.op     = sub ? OP_DIV_SUB : OP_DIV_ADD;
                    kind_next  = KIND_STEP;
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    case (kind_reg)
                        KIND_STEP:
                        begin
                            cmd.op     = sub ? OP_WR_SUB : OP_WR_ADD;
                            fld_next   = fld_reg + 3'd1;
                            state_next = S_STEP;
                        end
                        KIND_RES:
                        begin
                            cmd.op     = OP_WR_RES;
                            state_next = S_CLAMP;
                        end
                        KIND_ALIGN:
                        begin
                            cmd.op     = OP_WR_ALIGN;
                            state_next = (fld_reg == UNIT_YEAR) ? S_RES_START : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DAYS_INIT:
            begin
                cmd.op     = OP_DAYS_INIT;
                state_next = S_YEAR_LOOP;
            end
            S_YEAR_LOOP:
            begin
                if (stat.span_fit)
                    state_next = S_MONTH_LOOP;
                else
                    cmd.op = OP_YEAR_STEP;
            end
            S_MONTH_LOOP:
            begin
                if (stat.month_fit)
                    state_next = S_DAYS_FIN;
                else
                    cmd.op = OP_MONTH_STEP;
            end
            S_DAYS_FIN:
            begin
                cmd.op     = OP_DAYS_FIN;
                state_next = S_DONE;
            end
            S_RES_START:
            begin
                cmd.op     = OP_DIV_RES;
                kind_next  = KIND_RES;
                state_next = S_DIV_WAIT;
            end
            S_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                state_next = S_DONE;
            end
            S_ALIGN:
            begin
                cmd.op     = OP_ALIGN_CLEAR;
                state_next = S_ALIGN_DIV;
            end
            S_ALIGN_DIV:
            begin
                if (stat.amt_gt1)
                begin
                    cmd.op     = OP_DIV_ALIGN;
                    kind_next  = KIND_ALIGN;
                    state_next = S_DIV_WAIT;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!valid_reg || result_ready)
                begin
                    cmd.op     = OP_EMIT;
                    valid_next = 1'b1;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            kind_reg    <= KIND_STEP;
            command_reg <= CMD_LOAD;
            fld_reg     <= UNIT_SECOND;
            ready_reg   <= 1'b1;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            command_reg <= command_next;
            fld_reg     <= fld_next;
            ready_reg   <= ready_next;
            valid_reg   <= valid_next;
        end
    end

    assign item_ready   = ready_reg;
    assign result_valid = valid_reg;

endmodule

[hw/rtl/calendar_datetime_arithmetic.sv]
// ----------------------------------------------------------------------------
// calendar_datetime_arithmetic
// Gregorian date-time register with load, add, subtract and align commands.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      cda_pkg::in_item_t
//   result    out        result_valid / result_ready  cda_pkg::out_item_t
//
// One transaction is worked on at a time; an unused unit goes straight to the
// result, and a load recomputes the year residue by reciprocal division. Each
// carry through second, minute, hour or month uses reciprocal division, an
// align by a step above 1 uses bit-serial division, and a day carry takes one
// step per whole year and per month crossed.
// Reset clears the date-time to year 0, January 1, 00:00:00.
// A finished result waits in its own register; a new item is taken meanwhile,
// and a stalled result holds the next one back only at its final step.
// ----------------------------------------------------------------------------
module calendar_datetime_arithmetic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  cda_pkg::in_item_t    item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output cda_pkg::out_item_t   result
);
    import cda_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    cda_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_command (item.command),
        .item_unit    (item.unit),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    // date-time datapath
    cda_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule

[hw/rtl/cda_checker.sv]
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks for the date-time block, bound to the top level.
// ----------------------------------------------------------------------------
module cda_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input cda_pkg::out_item_t  result
);
    import cda_pkg::*;

    // result transaction holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // stalled result payload is unchanged
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // one item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item taken while busy");

    // emitted date-time is well formed
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.out_month != 4'd0 && result.out_month <= MONTH_MAX
            && result.out_day != 5'd0 && result.out_hour <= HOUR_MAX
            && result.out_minute <= SEC_MAX && result.out_second <= SEC_MAX)
        else $error("result date-time out of range");

endmodule

bind calendar_datetime_arithmetic cda_checker u_cda_checker (.*);
